>>> design/mbd_pkg.sv
// Shared types for the mipmap box downsampler: controller states, control structs and widths.
package mbd_pkg;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LEVEL,
		ST_CALC
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic restart;
		logic store_left;
		logic mem_rd;
		logic store_sum;
		logic emit;
		logic advance;
		logic next_lvl;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic zero_size;
		logic col_bit;
		logic row_bit;
		logic last;
		logic final_lvl;
		logic out_free;
	} status_t;

	localparam int unsigned CH_W     = 8;
	localparam int unsigned TEXEL_W  = 4 * CH_W;
	localparam int unsigned SUM_W    = CH_W + 1;
	localparam int unsigned PAIR_W   = 4 * SUM_W;
	localparam int unsigned SIZE_W   = 4;
	localparam int unsigned LEVEL_W  = 4;
	localparam int unsigned POS_W    = 9;
	localparam int unsigned OUT_W    = 56;

endpackage

>>> design/mbd_ctrl.sv
// Controller state machine of the mipmap box downsampler.
module mbd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  mbd_pkg::status_t status,
	output mbd_pkg::cmd_t    cmd
);
	import mbd_pkg::*;

	state_t state_q;
	state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && !status.zero_size) begin
					state_nxt = ST_LEVEL;
				end
			end
			ST_LEVEL: begin
				if (!status.col_bit) begin
					state_nxt = ST_IDLE;
				end else begin
					state_nxt = ST_CALC;
				end
			end
			ST_CALC: begin
				if (!status.row_bit) begin
					state_nxt = ST_IDLE;
				end else if (status.out_free) begin
					state_nxt = status.final_lvl ? ST_IDLE : ST_LEVEL;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.load    = s_tvalid;
				cmd.restart = s_tvalid && status.zero_size;
			end
			ST_LEVEL: begin
				cmd.store_left = !status.col_bit;
				cmd.advance    = !status.col_bit;
				cmd.mem_rd     = status.col_bit;
			end
			ST_CALC: begin
				if (!status.row_bit) begin
					cmd.store_sum = 1'b1;
					cmd.advance   = 1'b1;
				end else if (status.out_free) begin
					// Below the top level the averaged texel still goes into the next level.
					cmd.emit     = 1'b1;
					cmd.advance  = status.final_lvl;
					cmd.next_lvl = !status.final_lvl;
				end
			end
			default: cmd = '0;
		endcase
	end

endmodule

>>> design/mbd_datapath.sv
// Datapath of the mipmap box downsampler: position, pending texels, pair-sum line and output.
module mbd_datapath #(
	parameter int unsigned MAX_SIZE_LOG2 = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic [mbd_pkg::SIZE_W-1:0]  cfg_data,
	input  logic [mbd_pkg::TEXEL_W-1:0] s_tdata,
	input  logic                        m_tready,
	output logic                        m_tvalid,
	output logic [mbd_pkg::OUT_W-1:0]   m_tdata,
	output logic                        m_tlast,
	input  mbd_pkg::cmd_t               cmd,
	output mbd_pkg::status_t            status
);
	import mbd_pkg::*;

	localparam int unsigned M     = MAX_SIZE_LOG2;
	localparam int unsigned LW    = $clog2(M + 1);
	localparam int unsigned DEPTH = (1 << M) - 1;

	logic [SIZE_W-1:0]  size_q;
	logic [M-1:0]       col_q;
	logic [M-1:0]       row_q;
	logic [LW-1:0]      lvl_q;
	logic [TEXEL_W-1:0] cur_q;
	logic [TEXEL_W-1:0] left_q [M];
	logic [PAIR_W-1:0]  sums_mem [DEPTH];
	logic [PAIR_W-1:0]  rd_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;
	logic               out_last_q;

	logic [LW-1:0]      eff;
	logic [M:0]         col_sh;
	logic [M:0]         row_sh;
	logic [M:0]         side_m1;
	logic [M-1:0]       px;
	logic [M-1:0]       py;
	logic [M:0]         base_idx;
	logic [M-1:0]       idx;
	logic [PAIR_W-1:0]  hsum;
	logic [TEXEL_W-1:0] avg;
	logic [LW:0]        lvl_p1;
	logic [M+8:0]       px_ext;
	logic [M+8:0]       py_ext;

	// Effective size saturated at the largest supported image
	always_comb begin
		if ({{(32-SIZE_W){1'b0}}, size_q} > M) begin
			eff = LW'(M);
		end else begin
			eff = LW'(size_q);
		end
	end

	// Position within the current level and the pair-sum line address
	always_comb begin
		col_sh   = {1'b0, col_q} >> lvl_q;
		row_sh   = {1'b0, row_q} >> lvl_q;
		px       = M'(col_sh >> 1);
		py       = M'(row_sh >> 1);
		base_idx = ({1'b1, {M{1'b0}}}) - (({{M{1'b0}}, 1'b1}) << (LW'(M) - lvl_q));
		idx      = M'(base_idx + {1'b0, px});
		side_m1  = (({{M{1'b0}}, 1'b1}) << eff) - 1'b1;
		lvl_p1   = {1'b0, lvl_q} + 1'b1;
		px_ext   = {9'b0, px};
		py_ext   = {9'b0, py};
	end

	// Horizontal pair sum and the rounded 2x2 average per channel
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			hsum[c*SUM_W +: SUM_W] = {1'b0, left_q[lvl_q][c*CH_W +: CH_W]}
				+ {1'b0, cur_q[c*CH_W +: CH_W]};
			avg[c*CH_W +: CH_W] = CH_W'(({2'b0, hsum[c*SUM_W +: SUM_W]}
				+ {2'b0, rd_q[c*SUM_W +: SUM_W]} + 11'd2) >> 2);
		end
	end

	// Status toward the controller
	always_comb begin
		status.zero_size = (eff == '0);
		status.col_bit   = col_sh[0];
		status.row_bit   = row_sh[0];
		status.final_lvl = (lvl_p1 == {1'b0, eff});
		status.last      = status.final_lvl || !(col_sh[1] && row_sh[1]);
		status.out_free  = !out_valid_q || m_tready;
	end

	// Size register, position counters and level counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(8);
			col_q  <= '0;
			row_q  <= '0;
			lvl_q  <= '0;
		end else begin
			if (cfg_valid) begin
				size_q <= cfg_data;
				col_q  <= '0;
				row_q  <= '0;
			end else if (cmd.restart) begin
				col_q <= '0;
				row_q <= '0;
			end else if (cmd.advance) begin
				if ({1'b0, col_q} == side_m1) begin
					col_q <= '0;
					if ({1'b0, row_q} == side_m1) begin
						row_q <= '0;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (cmd.load) begin
				lvl_q <= '0;
			end else if (cmd.next_lvl) begin
				lvl_q <= lvl_q + 1'b1;
			end
		end
	end

	// Current texel and pending left texels
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q <= s_tdata;
		end else if (cmd.emit) begin
			cur_q <= avg;
		end
		if (cmd.store_left) begin
			left_q[lvl_q] <= cur_q;
		end
	end

	// Pair-sum line memory with registered read
	always_ff @(posedge clk) begin
		if (cmd.store_sum) begin
			sums_mem[idx] <= hsum;
		end
		if (cmd.mem_rd) begin
			rd_q <= sums_mem[idx];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= {2'b0, avg, py_ext[POS_W-1:0], px_ext[POS_W-1:0],
				LEVEL_W'(lvl_p1)};
			out_last_q <= status.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

>>> design/mipmap_box_downsampler_unit.sv
// Top level of the mipmap box downsampler: controller plus datapath.
// Level results are registered in the output register as the controller walks the levels
// after the texel beat is taken; that register stalls the level walk when full.
// A new texel beat is taken only in the idle state, once the previous texel's level walk
// has finished, stalls included.
// Reset (arst_n low, asynchronous) restarts at column 0, row 0 with size_log2 8.
module mipmap_box_downsampler_unit #(
	parameter int unsigned MAX_SIZE_LOG2 = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [mbd_pkg::SIZE_W-1:0]  cfg_data,   // size_log2
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [mbd_pkg::TEXEL_W-1:0] s_tdata,    // red, green, blue, alpha
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [mbd_pkg::OUT_W-1:0]   m_tdata,    // level, col, row, out_red,
	                                                // out_green, out_blue, out_alpha
	output logic                        m_tlast     // last_of_run
);
	import mbd_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	mbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	mbd_datapath #(
		.MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

>>> design/mbd_checker.sv
// Port checker for the mipmap box downsampler and its bind to the top level.
module mbd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [mbd_pkg::OUT_W-1:0]   m_tdata,
	input logic                        m_tlast
);
	import mbd_pkg::*;

	// A stalled result beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result beat changed while stalled");

	// While a non-final result waits, the texel is still being worked on
	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input accepted before run finished");

	// Levels start at one and the pad bits stay zero
	a_level_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[LEVEL_W-1:0] != '0 && m_tdata[OUT_W-1:OUT_W-2] == 2'b00)
		else $error("bad level or padding in result beat");

endmodule

bind mipmap_box_downsampler_unit mbd_checker u_mbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
